// ----- src/ofrt_pkg.sv -----
// shared types and constants of the open-file reference-count table
// slot entry layout, write command, status codes and field widths
// no dependencies
`default_nettype none

package ofrt_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int COUNT_BITS = 8;
  localparam int SLOT_W = $clog2(SLOT_COUNT);

  // fixed field widths of the stream payload
  localparam int FILE_W = 7;
  localparam int IDX_W = 4;
  localparam int STAT_W = 3;
  localparam int OUT_CNT_W = 8;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic KIND_OPEN = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_JOINED      = 3'd0,
    ST_NEW         = 3'd1,
    ST_FULL        = 3'd2,
    ST_OVERFLOW    = 3'd3,
    ST_BAD_RELEASE = 3'd4
  } status_t;

  typedef struct packed {
    logic                  used;
    logic [FILE_W-1:0]     file;
    logic [COUNT_BITS-1:0] rd;
    logic [COUNT_BITS-1:0] wr;
  } slot_ent_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    slot_ent_t         ent;
  } slot_wr_t;

endpackage

`default_nettype wire

// ----- src/ofrt_cell.sv -----
// one slot cell of the rotating slot ring
// uses ofrt_pkg for the slot entry type
`default_nettype none

module ofrt_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 shift_en,
  input  ofrt_pkg::slot_ent_t from_next,
  input  wire                 wr_sel,
  input  ofrt_pkg::slot_ent_t wr_ent,
  output ofrt_pkg::slot_ent_t ent
);
  import ofrt_pkg::*;

  slot_ent_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else if (shift_en) begin
      ent_r <= from_next;
    end else if (wr_sel) begin
      ent_r <= wr_ent;
    end
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

// ----- src/ofrt_ctrl.sv -----
// scan and update controller of the slot table
// watches the ring head during a full rotation, then decides and writes back
// uses ofrt_pkg
`default_nettype none

module ofrt_ctrl (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_kind,
  input  wire  [ofrt_pkg::FILE_W-1:0]         in_file,
  input  wire                                 in_wen,
  input  wire  [ofrt_pkg::IDX_W-1:0]          in_sidx,
  input  ofrt_pkg::slot_ent_t                 head,
  output logic                                shift_en,
  output ofrt_pkg::slot_wr_t                  wr,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [ofrt_pkg::IDX_W-1:0]          out_slot,
  output logic [ofrt_pkg::STAT_W-1:0]         out_status,
  output logic [ofrt_pkg::OUT_CNT_W-1:0]      out_rd,
  output logic [ofrt_pkg::OUT_CNT_W-1:0]      out_wr,
  output logic                                out_freed
);
  import ofrt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE} state_t;

  state_t                state_r;
  logic [SLOT_W-1:0]     cnt_r;
  logic                  kind_r;
  logic [FILE_W-1:0]     file_r;
  logic                  wen_r;
  logic [IDX_W-1:0]      sidx_r;
  logic                  hit_r;
  logic                  have_free_r;
  logic [SLOT_W-1:0]     hit_idx_r;
  logic [SLOT_W-1:0]     free_idx_r;
  logic                  tgt_used_r;
  logic [FILE_W-1:0]     tgt_file_r;
  logic [COUNT_BITS-1:0] tgt_rd_r;
  logic [COUNT_BITS-1:0] tgt_wr_r;

  logic                  out_valid_r;
  logic [IDX_W-1:0]      out_slot_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [OUT_CNT_W-1:0]  out_rd_r;
  logic [OUT_CNT_W-1:0]  out_wr_r;
  logic                  out_freed_r;

  logic                  out_free;
  logic                  sidx_ok;
  logic [COUNT_BITS-1:0] rd_inc, wr_inc, rd_dec, wr_dec;
  slot_wr_t              wr_nxt;
  logic [IDX_W-1:0]      res_slot;
  status_t               res_status;
  logic [COUNT_BITS-1:0] res_rd, res_wr;
  logic                  res_freed;

  assign out_free = !out_valid_r || out_ready;
  assign sidx_ok  = int'(sidx_r) < SLOT_COUNT;
  assign rd_inc   = tgt_rd_r + COUNT_BITS'(1);
  assign wr_inc   = tgt_wr_r + COUNT_BITS'(wen_r);
  assign rd_dec   = tgt_rd_r - COUNT_BITS'(1);
  assign wr_dec   = tgt_wr_r - COUNT_BITS'(wen_r);

  always_comb begin
    wr_nxt     = '0;
    res_slot   = '0;
    res_status = ST_JOINED;
    res_rd     = '0;
    res_wr     = '0;
    res_freed  = 1'b0;
    if (kind_r == KIND_OPEN) begin
      if (hit_r) begin
        res_slot = IDX_W'(hit_idx_r);
        if (tgt_rd_r == COUNT_MAX || (wen_r && tgt_wr_r == COUNT_MAX)) begin
          res_status = ST_OVERFLOW;
          res_rd     = tgt_rd_r;
          res_wr     = tgt_wr_r;
        end else begin
          res_status   = ST_JOINED;
          res_rd       = rd_inc;
          res_wr       = wr_inc;
          wr_nxt.en    = 1'b1;
          wr_nxt.idx   = hit_idx_r;
          wr_nxt.ent   = '{used: 1'b1, file: file_r, rd: rd_inc, wr: wr_inc};
        end
      end else if (!have_free_r) begin
        res_status = ST_FULL;
      end else begin
        res_slot   = IDX_W'(free_idx_r);
        res_status = ST_NEW;
        res_rd     = COUNT_BITS'(1);
        res_wr     = COUNT_BITS'(wen_r);
        wr_nxt.en  = 1'b1;
        wr_nxt.idx = free_idx_r;
        wr_nxt.ent = '{used: 1'b1, file: file_r, rd: COUNT_BITS'(1),
                       wr: COUNT_BITS'(wen_r)};
      end
    end else begin
      res_slot = sidx_r;
      if (!sidx_ok) begin
        res_status = ST_BAD_RELEASE;
      end else if (!tgt_used_r || (wen_r && tgt_wr_r == '0) || tgt_rd_r == '0) begin
        res_status = ST_BAD_RELEASE;
        res_rd     = tgt_rd_r;
        res_wr     = tgt_wr_r;
      end else begin
        res_status = ST_JOINED;
        wr_nxt.en  = 1'b1;
        wr_nxt.idx = SLOT_W'(sidx_r);
        if (rd_dec == '0) begin
          res_freed  = 1'b1;
          wr_nxt.ent = '0;
        end else begin
          // slot keeps its own file number
          res_rd     = rd_dec;
          res_wr     = wr_dec;
          wr_nxt.ent = '{used: 1'b1, file: tgt_file_r, rd: rd_dec, wr: wr_dec};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DECIDE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r      <= in_kind;
            file_r      <= in_file;
            wen_r       <= in_wen;
            sidx_r      <= in_sidx;
            hit_r       <= 1'b0;
            have_free_r <= 1'b0;
            hit_idx_r   <= '0;
            free_idx_r  <= '0;
            tgt_used_r  <= 1'b0;
            tgt_file_r  <= '0;
            tgt_rd_r    <= '0;
            tgt_wr_r    <= '0;
            cnt_r       <= '0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (kind_r == KIND_OPEN) begin
            if (!hit_r && head.used && head.file == file_r) begin
              hit_r      <= 1'b1;
              hit_idx_r  <= cnt_r;
              tgt_used_r <= 1'b1;
              tgt_file_r <= head.file;
              tgt_rd_r   <= head.rd;
              tgt_wr_r   <= head.wr;
            end else if (!hit_r && !head.used) begin
              have_free_r <= 1'b1;
              free_idx_r  <= cnt_r;
            end
          end else if (int'(cnt_r) == int'(sidx_r)) begin
            tgt_used_r <= head.used;
            tgt_file_r <= head.file;
            tgt_rd_r   <= head.rd;
            tgt_wr_r   <= head.wr;
          end
          cnt_r <= cnt_r + SLOT_W'(1);
          if (cnt_r == SLOT_W'(SLOT_COUNT - 1)) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          // a waiting result leaves only when it is taken
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_slot_r   <= res_slot;
            out_status_r <= res_status;
            out_rd_r     <= OUT_CNT_W'(res_rd);
            out_wr_r     <= OUT_CNT_W'(res_wr);
            out_freed_r  <= res_freed;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready   = state_r == S_IDLE;
  assign shift_en   = state_r == S_SCAN;
  assign wr.en      = wr_nxt.en && state_r == S_DECIDE && out_free;
  assign wr.idx     = wr_nxt.idx;
  assign wr.ent     = wr_nxt.ent;
  assign out_valid  = out_valid_r;
  assign out_slot   = out_slot_r;
  assign out_status = out_status_r;
  assign out_rd     = out_rd_r;
  assign out_wr     = out_wr_r;
  assign out_freed  = out_freed_r;

endmodule

`default_nettype wire

// ----- src/open_file_refcount_table.sv -----
// top level of the open-file reference-count table
// a ring of ofrt_cell slots scanned by ofrt_ctrl; uses ofrt_pkg
`default_nettype none

// Table of SLOT_COUNT open-file slots, each holding a file number, a reader
// count and a writer count. An open transaction (tuser 0) joins the slot that
// already holds the file, or else claims the highest-numbered free slot, and
// adds a reader plus a writer when write_enable is set. A release transaction
// (tuser 1) names a slot and takes a reader (and a writer) off it; the slot is
// freed when its readers reach zero. A full table, a count overflow and a bad
// release return an error status and leave the table alone. Every input
// transaction yields exactly one result transaction. The slots sit in a ring
// of cells that rotates one position a cycle past a single compare point
// while scanning: an item is accepted, scanned over a full rotation, then
// decided and written back when the output is free. One item is worked on
// at a time; the result sits in an output register, so the next item is
// taken while the previous result waits. File numbers are not range checked.
module open_file_refcount_table (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [6:0] file_number, [7] write_enable, [11:8] slot_index, [15:12] zero
  input  wire  [ofrt_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] kind: 0 open, 1 release
  input  wire                                 in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [3:0] slot, [6:4] status, [14:7] readers, [22:15] writers, [23] slot_freed
  output logic [ofrt_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import ofrt_pkg::*;

  slot_ent_t             ent [SLOT_COUNT];
  logic                  shift_en;
  slot_wr_t              wr;
  logic [IDX_W-1:0]      res_slot;
  logic [STAT_W-1:0]     res_status;
  logic [OUT_CNT_W-1:0]  res_rd, res_wr;
  logic                  res_freed;

  // cell j takes from cell j+1, so the head (cell 0) walks through slot 0..N-1
  for (genvar j = 0; j < SLOT_COUNT; j++) begin : g_cell
    ofrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (shift_en),
      .from_next (ent[(j + 1) % SLOT_COUNT]),
      .wr_sel    (wr.en && wr.idx == SLOT_W'(j)),
      .wr_ent    (wr.ent),
      .ent       (ent[j])
    );
  end

  ofrt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_file    (in_tdata[FILE_W-1:0]),
    .in_wen     (in_tdata[FILE_W]),
    .in_sidx    (in_tdata[FILE_W+1 +: IDX_W]),
    .head       (ent[0]),
    .shift_en   (shift_en),
    .wr         (wr),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_slot   (res_slot),
    .out_status (res_status),
    .out_rd     (res_rd),
    .out_wr     (res_wr),
    .out_freed  (res_freed)
  );

  // result packing, lowest field first
  assign out_tdata = {res_freed, res_wr, res_rd, res_status, res_slot};

endmodule

`default_nettype wire

// ----- verif/open_file_refcount_table_tb.sv -----
// self-checking testbench for open_file_refcount_table: directed table then random
// opens and releases, each result checked against a typed result or a slot-table predictor
// depends on ofrt_pkg and the open_file_refcount_table rtl
`default_nettype none

module open_file_refcount_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ofrt_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES = 300;      // long receiver stall
  localparam int HOLD_AFTER = 60;        // results seen before the stall
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction
  localparam int DRAIN_CYCLES = 40;
  localparam int BURST_OPENS = 257;      // enough joins to pass the count ceiling

  // one result transaction
  typedef struct packed {
    logic [IDX_W-1:0]     slot;
    status_t              status;
    logic [OUT_CNT_W-1:0] readers;
    logic [OUT_CNT_W-1:0] writers;
    logic                 freed;
  } file_result_t;

  // one row of the directed table
  typedef struct {
    logic              kind;
    logic [FILE_W-1:0] file;
    logic              wen;
    logic [IDX_W-1:0]  sidx;
    bit                typed;
    file_result_t      want;
  } op_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // predictor copy of the slot table
  logic                  tbl_used [SLOT_COUNT];
  logic [FILE_W-1:0]     tbl_file [SLOT_COUNT];
  logic [COUNT_BITS-1:0] tbl_rd   [SLOT_COUNT];
  logic [COUNT_BITS-1:0] tbl_wr   [SLOT_COUNT];

  file_result_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit hold_done = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  open_file_refcount_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // applies one open or release to the table copy and returns its result
  function automatic file_result_t apply_file_op(input logic kind,
                                                 input logic [FILE_W-1:0] file,
                                                 input logic wen,
                                                 input logic [IDX_W-1:0] sidx);
    file_result_t res;
    bit hit;
    bit have_free;
    int hit_idx;
    int free_idx;
    int i;
    int r;
    int w;
    res = '{slot: '0, status: ST_JOINED, readers: '0, writers: '0, freed: 1'b0};
    hit = 1'b0;
    have_free = 1'b0;
    hit_idx = 0;
    free_idx = 0;
    if (kind == KIND_OPEN) begin
      // the first slot holding the file is taken; later slots do not change it
      for (i = 0; i < SLOT_COUNT; i++) begin
        if (!hit && tbl_used[i] && tbl_file[i] == file) begin
          hit = 1'b1;
          hit_idx = i;
        end
        if (!hit && !tbl_used[i]) begin
          have_free = 1'b1;
          free_idx = i;
        end
      end
      if (hit) begin
        r = tbl_rd[hit_idx];
        w = tbl_wr[hit_idx];
        res.slot = IDX_W'(hit_idx);
        if (r + 1 > int'(COUNT_MAX) || w + int'(wen) > int'(COUNT_MAX)) begin
          res.status = ST_OVERFLOW;
          res.readers = OUT_CNT_W'(r);
          res.writers = OUT_CNT_W'(w);
        end else begin
          tbl_rd[hit_idx] = COUNT_BITS'(r + 1);
          tbl_wr[hit_idx] = COUNT_BITS'(w + int'(wen));
          res.status = ST_JOINED;
          res.readers = OUT_CNT_W'(r + 1);
          res.writers = OUT_CNT_W'(w + int'(wen));
        end
      end else if (!have_free) begin
        res.status = ST_FULL;
      end else begin
        tbl_used[free_idx] = 1'b1;
        tbl_file[free_idx] = file;
        tbl_rd[free_idx] = COUNT_BITS'(1);
        tbl_wr[free_idx] = COUNT_BITS'(wen);
        res.slot = IDX_W'(free_idx);
        res.status = ST_NEW;
        res.readers = OUT_CNT_W'(1);
        res.writers = OUT_CNT_W'(wen);
      end
    end else begin
      res.slot = sidx;
      if (!tbl_used[sidx] || (wen && tbl_wr[sidx] == 0) || tbl_rd[sidx] == 0) begin
        res.status = ST_BAD_RELEASE;
        res.readers = tbl_rd[sidx];
        res.writers = tbl_wr[sidx];
      end else begin
        tbl_wr[sidx] = tbl_wr[sidx] - COUNT_BITS'(wen);
        tbl_rd[sidx] = tbl_rd[sidx] - COUNT_BITS'(1);
        if (tbl_rd[sidx] == 0) begin
          tbl_used[sidx] = 1'b0;
          tbl_file[sidx] = '0;
          tbl_wr[sidx] = '0;
          res.freed = 1'b1;
        end
        res.status = ST_JOINED;
        res.readers = tbl_rd[sidx];
        res.writers = tbl_wr[sidx];
      end
    end
    return res;
  endfunction

  function automatic op_row_t row(input logic kind, input logic [FILE_W-1:0] file,
                                  input logic wen, input logic [IDX_W-1:0] sidx,
                                  input bit typed, input file_result_t want);
    op_row_t r;
    r.kind = kind;
    r.file = file;
    r.wen = wen;
    r.sidx = sidx;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // offers one transaction, waits for acceptance and records what must come back;
  // entered and left at a falling edge
  task automatic send_op(input logic kind, input logic [FILE_W-1:0] file,
                         input logic wen, input logic [IDX_W-1:0] sidx,
                         input bit typed, input file_result_t want);
    file_result_t pred;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, sidx, wen, file};
    in_tuser <= kind;
    do @(posedge clk); while (!in_tready);
    pred = apply_file_op(kind, file, wen, sidx);
    pending_results.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // result side: random ready, plus one long hold-off so the input backs up
  initial begin : result_ready
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    file_result_t want;
    file_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got.slot = out_tdata[3:0];
      got.status = status_t'(out_tdata[6:4]);
      got.readers = out_tdata[14:7];
      got.writers = out_tdata[22:15];
      got.freed = out_tdata[23];
      if (pending_results.size() == 0) begin
        errors++;
        $error("unexpected result transaction: tdata %h", out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.slot !== want.slot) begin
          errors++;
          $error("slot: expected %0d, actual %0d", want.slot, got.slot);
        end
        if (got.status !== want.status) begin
          errors++;
          $error("status: expected %0d, actual %0d", want.status, got.status);
        end
        if (got.readers !== want.readers) begin
          errors++;
          $error("readers: expected %0d, actual %0d", want.readers, got.readers);
        end
        if (got.writers !== want.writers) begin
          errors++;
          $error("writers: expected %0d, actual %0d", want.writers, got.writers);
        end
        if (got.freed !== want.freed) begin
          errors++;
          $error("slot_freed: expected %0d, actual %0d", want.freed, got.freed);
        end
      end
    end
  end

  // watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    op_row_t      rows[$];
    int           used_list[$];
    int           rand_items[3];
    int           i;
    int           ph;
    int           n;
    int           pick;
    int           burst_slot;
    bit           free_found;
    bit           present;
    logic [FILE_W-1:0] burst_file;
    logic         kind;
    logic [FILE_W-1:0] file;
    logic         wen;
    logic [IDX_W-1:0] sidx;
    rand_items = '{230, 230, 170};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    for (i = 0; i < SLOT_COUNT; i++) begin
      tbl_used[i] = 1'b0;
      tbl_file[i] = '0;
      tbl_rd[i] = '0;
      tbl_wr[i] = '0;
    end

    // directed table; typed results where they are plain from the rules
    rows.push_back(row(KIND_RELEASE, 7'd0, 1'b0, 4'd3, 1,       // release of an unused slot
                       '{4'd3, ST_BAD_RELEASE, 8'd0, 8'd0, 1'b0}));
    rows.push_back(row(KIND_OPEN, 7'd0, 1'b0, 4'd15, 1,         // fresh table: top slot
                       '{4'd15, ST_NEW, 8'd1, 8'd0, 1'b0}));
    rows.push_back(row(KIND_OPEN, 7'd127, 1'b1, 4'd0, 1,
                       '{4'd14, ST_NEW, 8'd1, 8'd1, 1'b0}));
    rows.push_back(row(KIND_OPEN, 7'd0, 1'b1, 4'd9, 1,          // join as a writer
                       '{4'd15, ST_JOINED, 8'd2, 8'd1, 1'b0}));
    rows.push_back(row(KIND_RELEASE, 7'd85, 1'b1, 4'd15, 1,
                       '{4'd15, ST_JOINED, 8'd1, 8'd0, 1'b0}));
    rows.push_back(row(KIND_RELEASE, 7'd42, 1'b1, 4'd15, 1,     // writer count already zero
                       '{4'd15, ST_BAD_RELEASE, 8'd1, 8'd0, 1'b0}));
    rows.push_back(row(KIND_RELEASE, 7'd0, 1'b0, 4'd15, 1,      // last reader frees the slot
                       '{4'd15, ST_JOINED, 8'd0, 8'd0, 1'b1}));
    // fill every remaining slot
    for (i = 1; i <= 15; i++)
      rows.push_back(row(KIND_OPEN, FILE_W'(i), i[0], IDX_W'(i), 0, '0));
    rows.push_back(row(KIND_OPEN, 7'd100, 1'b0, 4'd0, 1,        // no match, no room
                       '{4'd0, ST_FULL, 8'd0, 8'd0, 1'b0}));
    rows.push_back(row(KIND_RELEASE, 7'd0, 1'b0, 4'd0, 0, '0));
    rows.push_back(row(KIND_OPEN, 7'd100, 1'b1, 4'd5, 0, '0)); // file number 100, taken as is

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    in_idle_pct = 32;
    out_idle_pct = 77;
    foreach (rows[k])
      send_op(rows[k].kind, rows[k].file, rows[k].wen, rows[k].sidx, rows[k].typed,
              rows[k].want);

    for (ph = 0; ph < 3; ph++) begin
      in_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 77 : 0;
      out_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 32 : 0;

      if (ph == 2) begin
        // drive one fresh slot up against the count ceiling
        free_found = 1'b0;
        for (i = 0; i < SLOT_COUNT; i++)
          if (!tbl_used[i]) free_found = 1'b1;
        if (!free_found) begin
          while (tbl_used[0])
            send_op(KIND_RELEASE, FILE_W'($urandom), tbl_wr[0] != 0, 4'd0, 0, '0);
        end
        burst_file = 7'd64;
        do begin
          present = 1'b0;
          for (i = 0; i < SLOT_COUNT; i++)
            if (tbl_used[i] && tbl_file[i] == burst_file) present = 1'b1;
          if (present) burst_file = burst_file + 1;
        end while (present);
        for (n = 0; n < BURST_OPENS; n++)
          send_op(KIND_OPEN, burst_file, 1'b1, IDX_W'($urandom), 0, '0);
        burst_slot = 0;
        for (i = 0; i < SLOT_COUNT; i++)
          if (tbl_used[i] && tbl_file[i] == burst_file) burst_slot = i;
        // readers drop below the writers, then the writer count overflows alone
        send_op(KIND_RELEASE, burst_file, 1'b0, IDX_W'(burst_slot), 0, '0);
        send_op(KIND_OPEN, burst_file, 1'b1, IDX_W'($urandom), 0, '0);
        send_op(KIND_OPEN, burst_file, 1'b0, IDX_W'($urandom), 0, '0);
        send_op(KIND_OPEN, burst_file, 1'b0, IDX_W'($urandom), 0, '0);
      end

      for (n = 0; n < rand_items[ph]; n++) begin
        used_list.delete();
        for (i = 0; i < SLOT_COUNT; i++)
          if (tbl_used[i]) used_list.push_back(i);
        pick = $urandom_range(99);
        file = FILE_W'($urandom);
        wen = 1'($urandom);
        sidx = IDX_W'($urandom);
        if (pick < 85 && (pick < 45 || used_list.size() == 0)) begin
          // open: mostly a small pool of files so joins and a full table happen
          kind = KIND_OPEN;
          if ($urandom_range(9) != 0) file = FILE_W'($urandom_range(0, 19));
        end else if (pick < 85) begin
          // well-formed release of a slot in use
          kind = KIND_RELEASE;
          sidx = IDX_W'(used_list[$urandom_range(0, used_list.size() - 1)]);
          if (tbl_wr[sidx] == 0) wen = 1'b0;
        end else begin
          // arbitrary release, often bad
          kind = KIND_RELEASE;
        end
        send_op(kind, file, wen, sidx, 0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
src/ofrt_pkg.sv
src/ofrt_cell.sv
src/ofrt_ctrl.sv
src/open_file_refcount_table.sv
verif/open_file_refcount_table_tb.sv
